@@ sv/bu2x_pkg.sv @@
// Shared types and constants for the 2x bilinear upscaler.
// Holds pixel and coordinate types and the result-select encoding.
// No dependencies.
package bu2x_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 11;
    localparam int SIDE_W  = 11;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SIDE_W-1:0]  side_t;

    // Which of the up to four results of one pixel is on the output
    typedef enum logic [1:0] {
        SEL_DIAG  = 2'd0,
        SEL_VERT  = 2'd1,
        SEL_HORIZ = 2'd2,
        SEL_ORIG  = 2'd3
    } res_sel_t;

    // Bit positions in the pending-result mask
    localparam int MASK_DIAG  = 3;
    localparam int MASK_VERT  = 2;
    localparam int MASK_HORIZ = 1;
    localparam int MASK_ORIG  = 0;

endpackage

@@ sv/bilinear_upscale_2x_core.sv @@
// Top level of the streaming 2x bilinear upscaler for a square image.
// Holds the line store, the pixel pipeline and the result sequencer.
// Depends on bu2x_pkg.
//
// Usage:
//   Pixels of a square image of side image_side arrive in raster order on the
//   pixel_in channel (in_valid / in_stall). For each pixel at (r,c) the block
//   emits 1 to 4 tagged beats on the output channel (out_valid / out_stall):
//   diagonal mean, vertical mean, horizontal mean, then the original pixel,
//   which carries last_of_item. Coordinates refer to the (2S-1)-square image.
//   image_side is written on the cfg channel (cfg_valid / cfg_ready, always
//   ready) while the block is idle; a write restarts the image at (0,0).
//   The first beat of a pixel passes the holding stage and then the sequencer
//   register before it is on the output.
//   Throughput: one output beat per cycle while out_stall is low; the single
//   output sequencer sets this rate.
//   The line store is one read-first RAM port, one access per accepted pixel.
//   A one-pixel holding stage lets the next pixel in while results drain.
//   Reset: counters, neighbour pixels and valids clear, image_side becomes 64;
//   the line store is not cleared (row 0 never uses what it reads).
//   When the receiver stalls, the current beat holds and in_stall rises as
//   soon as the holding stage is full.
module bilinear_upscale_2x_core #(
    parameter int MAX_SIDE = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  bu2x_pkg::side_t   image_side,
    // input pixels
    input  logic              in_valid,
    output logic              in_stall,
    input  bu2x_pkg::pix_t    pixel_in,
    // output beats
    output logic              out_valid,
    input  logic              out_stall,
    output bu2x_pkg::coord_t  out_row,
    output bu2x_pkg::coord_t  out_col,
    output bu2x_pkg::pix_t    out_value,
    output logic              last_of_item
);
    import bu2x_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd64;

    typedef logic [CW-1:0] cnt_t;

    // configuration and position
    side_t           side_reg;
    logic [SW-1:0]   eff_side;
    cnt_t            row_reg, row_next;
    cnt_t            col_reg, col_next;
    cnt_t            row_cur, col_cur;
    pix_t            left_reg;

    // line store
    pix_t            line_mem [MAX_SIDE];
    pix_t            up_rd_reg;

    // holding stage
    logic            s1_valid_reg;
    pix_t            s1_pix_reg;
    pix_t            s1_left_reg;
    cnt_t            s1_row_reg;
    cnt_t            s1_col_reg;
    pix_t            prev_up_reg;

    // result sequencer
    logic            s2_valid_reg;
    logic [3:0]      mask_reg, mask_next;
    pix_t            diag_reg, vert_reg, horiz_reg, pix_reg;
    coord_t          r2_reg, c2_reg;
    res_sel_t        sel;

    logic            cfg_fire, in_fire, out_fire, s2_load, s2_done;
    logic [9:0]      diag_sum;
    logic [8:0]      vert_sum, horiz_sum;
    logic [CW:0]     col_inc, row_inc;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = s2_valid_reg && !out_stall;
    assign s2_done   = out_fire && (sel == SEL_ORIG);
    assign s2_load   = s1_valid_reg && (!s2_valid_reg || s2_done);
    assign in_stall  = s1_valid_reg && !s2_load;

    // Clamp the side register to the range the line store covers
    always_comb
    begin
        if (32'(side_reg) > 32'(MAX_SIDE))
            eff_side = SW'(MAX_SIDE);
        else if (side_reg == '0)
            eff_side = SW'(1);
        else
            eff_side = SW'(side_reg);
    end

    // Current position (restart on stale counters) and the next one
    always_comb
    begin
        if (32'(row_reg) >= 32'(eff_side) || 32'(col_reg) >= 32'(eff_side))
        begin
            row_cur = '0;
            col_cur = '0;
        end
        else
        begin
            row_cur = row_reg;
            col_cur = col_reg;
        end
        col_inc  = {1'b0, col_cur} + (CW+1)'(1);
        row_inc  = {1'b0, row_cur} + (CW+1)'(1);
        row_next = row_cur;
        col_next = col_inc[CW-1:0];
        if (32'(col_inc) >= 32'(eff_side))
        begin
            col_next = '0;
            if (32'(row_inc) >= 32'(eff_side))
                row_next = '0;
            else
                row_next = row_inc[CW-1:0];
        end
    end

    // Hold configuration and advance the raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
            left_reg <= '0;
        end
        else if (cfg_fire)
        begin
            side_reg <= image_side;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else if (in_fire)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            left_reg <= pixel_in;
        end
    end

    // Line store: read the old entry and write the new pixel in one access
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            up_rd_reg          <= line_mem[col_cur];
            line_mem[col_cur]  <= pixel_in;
        end
    end

    // Holding stage valid and neighbour history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            prev_up_reg  <= '0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;
            if (s2_load)
                prev_up_reg <= up_rd_reg;
        end
    end

    // Holding stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg  <= pixel_in;
            s1_left_reg <= left_reg;
            s1_row_reg  <= row_cur;
            s1_col_reg  <= col_cur;
        end
    end

    // Rounded means of the pixel in the holding stage
    always_comb
    begin
        diag_sum  = 10'(prev_up_reg) + 10'(up_rd_reg) + 10'(s1_left_reg)
                  + 10'(s1_pix_reg) + 10'd2;
        vert_sum  = 9'(up_rd_reg) + 9'(s1_pix_reg) + 9'd1;
        horiz_sum = 9'(s1_left_reg) + 9'(s1_pix_reg) + 9'd1;
    end

    // Pick the first pending result
    always_comb
    begin
        if (mask_reg[MASK_DIAG])
            sel = SEL_DIAG;
        else if (mask_reg[MASK_VERT])
            sel = SEL_VERT;
        else if (mask_reg[MASK_HORIZ])
            sel = SEL_HORIZ;
        else
            sel = SEL_ORIG;
    end

    // Drop the result just delivered from the mask; a load sets the new pixel's mask
    always_comb
    begin
        mask_next = mask_reg;
        if (out_fire)
        begin
            case (sel)
                SEL_DIAG:  mask_next[MASK_DIAG]  = 1'b0;
                SEL_VERT:  mask_next[MASK_VERT]  = 1'b0;
                SEL_HORIZ: mask_next[MASK_HORIZ] = 1'b0;
                default:   mask_next[MASK_ORIG]  = 1'b0;
            endcase
        end
        if (s2_load)
        begin
            mask_next[MASK_DIAG]  = (s1_row_reg != '0) && (s1_col_reg != '0);
            mask_next[MASK_VERT]  = (s1_row_reg != '0);
            mask_next[MASK_HORIZ] = (s1_col_reg != '0);
            mask_next[MASK_ORIG]  = 1'b1;
        end
    end

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            mask_reg     <= '0;
        end
        else
        begin
            if (s2_load)
                s2_valid_reg <= 1'b1;
            else if (s2_done)
                s2_valid_reg <= 1'b0;
            mask_reg <= mask_next;
        end
    end

    // Sequencer payload
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            diag_reg  <= diag_sum[9:2];
            vert_reg  <= vert_sum[8:1];
            horiz_reg <= horiz_sum[8:1];
            pix_reg   <= s1_pix_reg;
            r2_reg    <= COORD_W'({s1_row_reg, 1'b0});
            c2_reg    <= COORD_W'({s1_col_reg, 1'b0});
        end
    end

    // Output beat selection
    always_comb
    begin
        case (sel)
            SEL_DIAG:
            begin
                out_row   = r2_reg - COORD_W'(1);
                out_col   = c2_reg - COORD_W'(1);
                out_value = diag_reg;
            end
            SEL_VERT:
            begin
                out_row   = r2_reg - COORD_W'(1);
                out_col   = c2_reg;
                out_value = vert_reg;
            end
            SEL_HORIZ:
            begin
                out_row   = r2_reg;
                out_col   = c2_reg - COORD_W'(1);
                out_value = horiz_reg;
            end
            default:
            begin
                out_row   = r2_reg;
                out_col   = c2_reg;
                out_value = pix_reg;
            end
        endcase
    end

    assign out_valid    = s2_valid_reg;
    assign last_of_item = (sel == SEL_ORIG);

    // An item in the sequencer always still owes its original pixel
    a_orig_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> mask_reg[MASK_ORIG])
        else $error("sequencer holds an item without its final beat");

    // A beat that is not the last keeps the item in the sequencer
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !last_of_item) |=> (s2_valid_reg && $stable(pix_reg)))
        else $error("item left the sequencer before its last beat");

    // An accepted pixel always lands in the holding stage
    a_hold_filled: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted pixel lost");

    // An empty sequencer takes the held pixel at once
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_valid_reg) |-> s2_load)
        else $error("sequencer idle while a pixel waits");

endmodule
